/* hw/rtl/tsws_pkg.sv */
// Package for the TFTP stop-and-wait sender: field widths, codes and shared types.
// Used by the channel interfaces and by every module of the sender.
`default_nettype none

package tsws_pkg;

   localparam int CMD_W       = 2;
   localparam int LEN_W       = 10;
   localparam int OPCODE_W    = 16;
   localparam int BLOCK_W     = 16;
   localparam int OFFSET_W    = 25;
   localparam int CHUNK_W     = 10;
   localparam int ACTION_W    = 3;
   localparam int TRIES_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;

   localparam int DEFAULT_BLOCK_BYTES = 512;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [OPCODE_W-1:0] ACK_OPCODE      = OPCODE_W'(4);
   localparam logic [LEN_W-1:0]    MIN_PACKET      = LEN_W'(4);
   localparam logic [TRIES_W-1:0]  MAX_TRIES_RESET = TRIES_W'(5);

   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 2'd0,
      CMD_PACKET  = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_ERROR   = 2'd3
   } cmd_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TRANSMIT    = 3'd0,
      ACT_IGNORED     = 3'd1,
      ACT_DONE        = 3'd2,
      ACT_ABORT_RETRY = 3'd3,
      ACT_ABORT_ERROR = 3'd4
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRANSFER_LENGTH = 2'd0,
      CSR_MAX_TRIES       = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      CLS_START   = 3'd0,
      CLS_ACK     = 3'd1,
      CLS_IGNORE  = 3'd2,
      CLS_TIMEOUT = 3'd3,
      CLS_ERROR   = 3'd4
   } cls_type;

   typedef enum logic {
      PHASE_IDLE   = 1'b0,
      PHASE_ACTIVE = 1'b1
   } phase_type;

   typedef struct packed {
      cls_type              cls;
      logic [BLOCK_W-1:0]   rx_block;
   } entry_type;

   typedef struct packed {
      logic                               full;
      logic                               not_empty;
      logic [$clog2(QUEUE_DEPTH+1)-1:0]   count;
   } queue_status_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] transfer_length;
      logic [TRIES_W-1:0]  max_tries;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/tsws_if.sv */
// Channel interfaces of the TFTP stop-and-wait sender: request, response and register write.
// Depends on tsws_pkg for the field widths.
`default_nettype none

interface tsws_req_if;
   import tsws_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [LEN_W-1:0]     rx_length;
   logic [OPCODE_W-1:0]  rx_opcode;
   logic [BLOCK_W-1:0]   rx_block;
   modport source (output valid, cmd, rx_length, rx_opcode, rx_block, input ready);
   modport sink   (input valid, cmd, rx_length, rx_opcode, rx_block, output ready);
endinterface

interface tsws_rsp_if;
   import tsws_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [BLOCK_W-1:0]   block_id;
   logic [OFFSET_W-1:0]  byte_offset;
   logic [CHUNK_W-1:0]   chunk_length;
   modport source (output valid, action, block_id, byte_offset, chunk_length,
                   input ready);
   modport sink   (input valid, action, block_id, byte_offset, chunk_length,
                   output ready);
endinterface

interface tsws_csr_if;
   import tsws_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tsws_front.sv */
// Front end of the sender: accepts request transfers and classifies each event.
// Depends on tsws_pkg and tsws_req_if; feeds tsws_queue.
`default_nettype none

module tsws_front (
   tsws_req_if.sink                     req_chan,
   input  tsws_pkg::queue_status_type   q_status,
   output logic                         push,
   output tsws_pkg::entry_type          push_entry
);
   import tsws_pkg::*;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   always_comb begin
      push_entry.rx_block = req_chan.rx_block;
      case (cmd_type'(req_chan.cmd))
         CMD_START: begin
            push_entry.cls = CLS_START;
         end
         CMD_PACKET: begin
            if (req_chan.rx_length < MIN_PACKET || req_chan.rx_opcode != ACK_OPCODE) begin
               push_entry.cls = CLS_IGNORE;
            end else begin
               push_entry.cls = CLS_ACK;
            end
         end
         CMD_TIMEOUT: begin
            push_entry.cls = CLS_TIMEOUT;
         end
         CMD_ERROR: begin
            push_entry.cls = CLS_ERROR;
         end
         default: begin
            push_entry.cls = CLS_IGNORE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/tsws_queue.sv */
// Short first-in first-out queue of classified events between front and back end.
// Depends on tsws_pkg for the entry and status types.
`default_nettype none

module tsws_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tsws_pkg::entry_type          push_entry,
   input  logic                         pop,
   output tsws_pkg::entry_type          head_entry,
   output tsws_pkg::queue_status_type   status
);
   import tsws_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry       = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;

endmodule

`default_nettype wire

/* hw/rtl/tsws_back.sv */
// Back end of the sender: transfer state machine and registered response stage.
// Depends on tsws_pkg and tsws_rsp_if; drains tsws_queue.
`default_nettype none

module tsws_back #(
   parameter int BLOCK_BYTES = tsws_pkg::DEFAULT_BLOCK_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tsws_pkg::cfg_type            cfg,
   input  tsws_pkg::entry_type          head_entry,
   input  tsws_pkg::queue_status_type   q_status,
   output logic                         pop,
   tsws_rsp_if.source                   rsp_chan
);
   import tsws_pkg::*;

   localparam int LEFT_W = OFFSET_W + 1;
   localparam logic [LEFT_W-1:0]   BLK_LEFT   = LEFT_W'(BLOCK_BYTES);
   localparam logic [OFFSET_W-1:0] BLK_OFFSET = OFFSET_W'(BLOCK_BYTES);

   phase_type             phase_ff, phase_in;
   logic [BLOCK_W-1:0]    block_ff, block_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [TRIES_W-1:0]    tries_ff, tries_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   action_type            action_ff, action_in;
   logic [BLOCK_W-1:0]    rsp_block_ff;
   logic [OFFSET_W-1:0]   rsp_offset_ff;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;

   logic [LEFT_W-1:0]     length_ext;
   logic [LEFT_W-1:0]     left_cur;
   logic [LEFT_W-1:0]     left_next;
   logic [LEFT_W-1:0]     chunk_cur;
   logic [LEFT_W-1:0]     chunk_next;
   logic [LEFT_W-1:0]     chunk_start;
   logic [LEFT_W-1:0]     chunk_sel;

   assign pop = q_status.not_empty && (!rsp_valid_ff || rsp_chan.ready);

   assign length_ext  = {1'b0, cfg.transfer_length};
   assign left_cur    = length_ext - {1'b0, offset_ff};
   assign left_next   = left_cur - BLK_LEFT;
   assign chunk_cur   = left_cur[LEFT_W-1] ? '0 :
                        ((left_cur >= BLK_LEFT) ? BLK_LEFT : left_cur);
   assign chunk_next  = left_next[LEFT_W-1] ? '0 :
                        ((left_next >= BLK_LEFT) ? BLK_LEFT : left_next);
   assign chunk_start = (length_ext >= BLK_LEFT) ? BLK_LEFT : length_ext;

   always_comb begin
      phase_in  = phase_ff;
      block_in  = block_ff;
      offset_in = offset_ff;
      tries_in  = tries_ff;
      action_in = ACT_IGNORED;
      chunk_sel = chunk_cur;
      if (head_entry.cls == CLS_START) begin
         phase_in  = PHASE_ACTIVE;
         block_in  = BLOCK_W'(1);
         offset_in = '0;
         tries_in  = TRIES_W'(1);
         action_in = ACT_TRANSMIT;
         chunk_sel = chunk_start;
      end else if (phase_ff == PHASE_ACTIVE) begin
         case (head_entry.cls)
            CLS_ERROR: begin
               phase_in  = PHASE_IDLE;
               action_in = ACT_ABORT_ERROR;
            end
            CLS_TIMEOUT: begin
               if (tries_ff >= cfg.max_tries) begin
                  phase_in  = PHASE_IDLE;
                  action_in = ACT_ABORT_RETRY;
               end else begin
                  tries_in  = tries_ff + TRIES_W'(1);
                  action_in = ACT_TRANSMIT;
               end
            end
            CLS_ACK: begin
               if (head_entry.rx_block == block_ff) begin
                  if (chunk_cur < BLK_LEFT) begin
                     phase_in  = PHASE_IDLE;
                     action_in = ACT_DONE;
                  end else begin
                     offset_in = offset_ff + BLK_OFFSET;
                     block_in  = block_ff + BLOCK_W'(1);
                     tries_in  = TRIES_W'(1);
                     action_in = ACT_TRANSMIT;
                     chunk_sel = chunk_next;
                  end
               end
            end
            default: begin
               action_in = ACT_IGNORED;
            end
         endcase
      end
      chunk_in     = chunk_sel[CHUNK_W-1:0];
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         block_ff     <= '0;
         offset_ff    <= '0;
         tries_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            block_ff  <= block_in;
            offset_ff <= offset_in;
            tries_ff  <= tries_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff     <= action_in;
         rsp_block_ff  <= block_in;
         rsp_offset_ff <= offset_in;
         chunk_ff      <= chunk_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.action       = action_ff;
   assign rsp_chan.block_id     = rsp_block_ff;
   assign rsp_chan.byte_offset  = rsp_offset_ff;
   assign rsp_chan.chunk_length = chunk_ff;

endmodule

`default_nettype wire

/* hw/rtl/tftp_stop_and_wait_sender_unit.sv */
// Top level of the TFTP stop-and-wait sender: register file, front end, queue, back end.
// Depends on tsws_pkg, the tsws interfaces, tsws_front, tsws_queue and tsws_back.
//
//   Channel    Direction  Transfer carries
//   req_chan   in         cmd, rx_length, rx_opcode, rx_block
//   rsp_chan   out        action, block_id, byte_offset, chunk_length
//   csr_chan   in         index, data (register write)
//
// Each event gives exactly one response; one event per cycle is sustained while responses are taken.
// An accepted event is written into the queue at the transfer edge and then, when popped,
// passes through the registered response stage.
// Reset is synchronous and clears the transfer state, the queue and the response valid.
// A stalled response holds the back end while the queue fills; the request side then stalls.
// Register writes are always taken and act on the next event processed.
`default_nettype none

module tftp_stop_and_wait_sender_unit #(
   parameter int BLOCK_BYTES = tsws_pkg::DEFAULT_BLOCK_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   tsws_req_if.sink  req_chan,
   tsws_rsp_if.source rsp_chan,
   tsws_csr_if.sink  csr_chan
);
   import tsws_pkg::*;

   logic [OFFSET_W-1:0]  transfer_length_ff;
   logic [TRIES_W-1:0]   max_tries_ff;
   cfg_type              cfg;

   logic                 push;
   logic                 pop;
   entry_type            push_entry;
   entry_type            head_entry;
   queue_status_type     q_status;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_length_ff <= '0;
         max_tries_ff       <= MAX_TRIES_RESET;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_TRANSFER_LENGTH: begin
               transfer_length_ff <= csr_chan.data[OFFSET_W-1:0];
            end
            CSR_MAX_TRIES: begin
               max_tries_ff <= csr_chan.data[TRIES_W-1:0];
            end
            default: begin
               max_tries_ff <= max_tries_ff;
            end
         endcase
      end
   end

   assign cfg.transfer_length = transfer_length_ff;
   assign cfg.max_tries       = max_tries_ff;

   tsws_front u_front (
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   tsws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   tsws_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= ($clog2(QUEUE_DEPTH + 1))'(QUEUE_DEPTH))
      else $error("event queue holds more entries than its depth");

   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> q_status.not_empty)
      else $error("accepted event did not reach the queue");

   a_drain_responds: assert property (@(posedge clock) disable iff (reset)
      (q_status.not_empty && (!rsp_chan.valid || rsp_chan.ready)) |=> rsp_chan.valid)
      else $error("queued event did not produce a response");

endmodule

`default_nettype wire
